>>> rtl/tpsd_pkg.sv
// ----------------------------------------------------------------------------
// tpsd_pkg
// shared types and constants of the tone prescaler select block
// ----------------------------------------------------------------------------
package tpsd_pkg;

	localparam int ClkWidth   = 27;
	localparam int FreqWidth  = 16;
	localparam int DurWidth   = 16;
	localparam int CmpWidth   = 16;
	localparam int SelWidth   = 3;
	localparam int DivSteps   = ClkWidth;
	localparam int CntWidth   = $clog2(DivSteps);
	localparam int NumPresc   = 5;

	localparam logic [ClkWidth-1:0] ClockReset  = ClkWidth'(16000000);
	localparam logic [SelWidth-1:0] FallbackSel = 3'd4;
	localparam logic [ClkWidth-1:0] QuotMax     = ClkWidth'(32'h0001_0000);

	// right shift that turns clock/(2*freq) into clock/(2*prescaler*freq)
	localparam logic [3:0] PrescShift [NumPresc] = '{4'd0, 4'd3, 4'd6, 4'd8, 4'd10};

	typedef enum logic [1:0] {
		OP_PLAY = 2'd0,
		OP_TICK = 2'd1,
		OP_STOP = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_DIV  = 2'd1,
		ST_FIN  = 2'd2
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_div;
		logic out_free;
	} dp_status_t;

endpackage

>>> rtl/tpsd_ctrl.sv
// ----------------------------------------------------------------------------
// tpsd_ctrl
// sequencer: accept, divide over ClkWidth steps, finish into output register
// ----------------------------------------------------------------------------
module tpsd_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  tpsd_pkg::dp_status_t    st,
	output tpsd_pkg::ctrl_cmd_t     cmd
);

	tpsd_pkg::state_t                state_q, state_d;
	logic [tpsd_pkg::CntWidth-1:0]   cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpsd_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		cmd          = '0;
		in_ready     = 1'b0;
		case (state_q)
			tpsd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = st.need_div ? tpsd_pkg::ST_DIV : tpsd_pkg::ST_FIN;
				end
			end
			tpsd_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == tpsd_pkg::CntWidth'(tpsd_pkg::DivSteps - 1)) begin
					state_d = tpsd_pkg::ST_FIN;
				end
			end
			tpsd_pkg::ST_FIN: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = tpsd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tpsd_pkg::ST_IDLE;
			end
		endcase
	end

`ifndef SYNTH
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> st.out_free)
		else $error("finish issued while output register busy");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tpsd_pkg::ST_DIV) |-> (cnt_q < tpsd_pkg::CntWidth'(tpsd_pkg::DivSteps)))
		else $error("divide step count out of range");
	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tpsd_pkg::ST_DIV &&
		 cnt_q == tpsd_pkg::CntWidth'(tpsd_pkg::DivSteps - 1)) |=>
		(state_q == tpsd_pkg::ST_FIN))
		else $error("divide did not end after its last step");
`endif

endmodule

>>> rtl/tpsd_dp.sv
// ----------------------------------------------------------------------------
// tpsd_dp
// datapath: item registers, bit-serial divider, prescaler pick, tone state
// ----------------------------------------------------------------------------
module tpsd_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [tpsd_pkg::ClkWidth-1:0]       cfg_wr_data,
	input  logic [1:0]                          op,
	input  logic [tpsd_pkg::FreqWidth-1:0]      freq_hz,
	input  logic [tpsd_pkg::DurWidth-1:0]       duration_ms,
	input  tpsd_pkg::ctrl_cmd_t                 cmd,
	output tpsd_pkg::dp_status_t                st,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                active,
	output logic [tpsd_pkg::SelWidth-1:0]       prescale_sel,
	output logic [tpsd_pkg::CmpWidth-1:0]       compare_value,
	output logic                                just_stopped
);

	// configuration
	logic [tpsd_pkg::ClkWidth-1:0]  clock_hz_q;

	// captured item
	tpsd_pkg::op_t                  op_q;
	logic [tpsd_pkg::FreqWidth-1:0] freq_q;
	logic [tpsd_pkg::DurWidth-1:0]  dur_q;

	// divider: remainder and dividend/quotient shift register
	logic [tpsd_pkg::FreqWidth:0]   rem_q;
	logic [tpsd_pkg::ClkWidth-1:0]  quo_q;

	// tone state
	logic                           playing_q;
	logic                           timed_q;
	logic [tpsd_pkg::DurWidth-1:0]  ms_q;
	logic [tpsd_pkg::SelWidth-1:0]  held_sel_q;
	logic [tpsd_pkg::CmpWidth-1:0]  held_cmp_q;

	// output register
	logic                           out_valid_q;
	logic                           active_q;
	logic [tpsd_pkg::SelWidth-1:0]  sel_out_q;
	logic [tpsd_pkg::CmpWidth-1:0]  cmp_out_q;
	logic                           stopped_q;

	// divide step
	logic [tpsd_pkg::FreqWidth+1:0] shifted;
	logic [tpsd_pkg::FreqWidth+2:0] diff;
	logic [tpsd_pkg::FreqWidth:0]   divisor;
	logic                           ge;

	// prescaler pick
	logic                           found;
	logic [tpsd_pkg::SelWidth-1:0]  pick_sel;
	logic [tpsd_pkg::CmpWidth-1:0]  pick_cmp;
	logic [tpsd_pkg::ClkWidth-1:0]  qk;
	logic [tpsd_pkg::ClkWidth-1:0]  qk_m1;

	// next tone state
	logic                           playing_d, timed_d, ended_d;
	logic [tpsd_pkg::DurWidth-1:0]  ms_d, ms_dec;
	logic [tpsd_pkg::SelWidth-1:0]  held_sel_d;
	logic [tpsd_pkg::CmpWidth-1:0]  held_cmp_d;

	assign st.need_div = (tpsd_pkg::op_t'(op) == tpsd_pkg::OP_PLAY) && (freq_hz != '0);
	assign st.out_free = !out_valid_q || !out_stall;

	assign divisor = {freq_q, 1'b0};
	assign shifted = {rem_q, quo_q[tpsd_pkg::ClkWidth-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor};
	assign ge      = !diff[tpsd_pkg::FreqWidth+2];

	always_comb begin
		found    = 1'b0;
		pick_sel = tpsd_pkg::FallbackSel;
		pick_cmp = '0;
		qk       = '0;
		qk_m1    = '0;
		for (int k = 0; k < tpsd_pkg::NumPresc; k++) begin
			qk    = quo_q >> tpsd_pkg::PrescShift[k];
			qk_m1 = qk - 1'b1;
			if (!found && qk != '0 && qk <= tpsd_pkg::QuotMax) begin
				found    = 1'b1;
				pick_sel = tpsd_pkg::SelWidth'(k);
				pick_cmp = qk_m1[tpsd_pkg::CmpWidth-1:0];
			end
		end
	end

	always_comb begin
		playing_d  = playing_q;
		timed_d    = timed_q;
		ms_d       = ms_q;
		held_sel_d = held_sel_q;
		held_cmp_d = held_cmp_q;
		ended_d    = 1'b0;
		ms_dec     = (ms_q != '0) ? ms_q - 1'b1 : ms_q;
		case (op_q)
			tpsd_pkg::OP_PLAY: begin
				if (freq_q == '0) begin
					ended_d    = playing_q;
					playing_d  = 1'b0;
					timed_d    = 1'b0;
					ms_d       = '0;
					held_sel_d = '0;
					held_cmp_d = '0;
				end else begin
					playing_d  = 1'b1;
					timed_d    = (dur_q != '0);
					ms_d       = dur_q;
					held_sel_d = pick_sel;
					held_cmp_d = pick_cmp;
				end
			end
			tpsd_pkg::OP_TICK: begin
				if (playing_q && timed_q) begin
					ms_d = ms_dec;
					if (ms_dec == '0) begin
						ended_d    = 1'b1;
						playing_d  = 1'b0;
						timed_d    = 1'b0;
						held_sel_d = '0;
						held_cmp_d = '0;
					end
				end
			end
			tpsd_pkg::OP_STOP: begin
				ended_d    = playing_q;
				playing_d  = 1'b0;
				timed_d    = 1'b0;
				ms_d       = '0;
				held_sel_d = '0;
				held_cmp_d = '0;
			end
			default: begin
				ended_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q  <= tpsd_pkg::ClockReset;
			playing_q   <= 1'b0;
			timed_q     <= 1'b0;
			ms_q        <= '0;
			held_sel_q  <= '0;
			held_cmp_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				clock_hz_q <= cfg_wr_data;
			end
			if (cmd.finish) begin
				playing_q   <= playing_d;
				timed_q     <= timed_d;
				ms_q        <= ms_d;
				held_sel_q  <= held_sel_d;
				held_cmp_q  <= held_cmp_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= tpsd_pkg::op_t'(op);
			freq_q <= freq_hz;
			dur_q  <= duration_ms;
			rem_q  <= '0;
			quo_q  <= clock_hz_q;
		end else if (cmd.div_step) begin
			rem_q <= ge ? diff[tpsd_pkg::FreqWidth:0] : shifted[tpsd_pkg::FreqWidth:0];
			quo_q <= {quo_q[tpsd_pkg::ClkWidth-2:0], ge};
		end
		if (cmd.finish) begin
			active_q  <= playing_d;
			sel_out_q <= held_sel_d;
			cmp_out_q <= held_cmp_d;
			stopped_q <= ended_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign active        = active_q;
	assign prescale_sel  = sel_out_q;
	assign compare_value = cmp_out_q;
	assign just_stopped  = stopped_q;

`ifndef SYNTH
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !active_q) |-> (sel_out_q == '0 && cmp_out_q == '0))
		else $error("idle result carries prescaler or compare");
	a_stop_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && stopped_q) |-> !active_q)
		else $error("stopped result still active");
	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && active_q) |-> (sel_out_q <= tpsd_pkg::FallbackSel))
		else $error("prescaler select out of range");
`endif

endmodule

>>> rtl/tone_prescaler_select_with_duration_core.sv
// ----------------------------------------------------------------------------
// tone_prescaler_select_with_duration_core
// tone controller: picks timer prescaler and compare value, counts duration
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake             payload
//   cfg       in         cfg_wr_en             cfg_wr_data (clock_hz)
//   in        in         in_valid / in_stall   op, freq_hz, duration_ms
//   out       out        out_valid / out_stall active, prescale_sel,
//                                              compare_value, just_stopped
//
// a play with nonzero frequency runs 27 one-bit divide steps of clock/(2*freq)
// after its transfer, then a finish step loads the result register; tick, stop,
// zero-frequency play and unused op go straight to the finish step
// in_stall is high from transfer until the result is loaded, so the block takes
// no new item until the previous one has loaded its result
// finish waits while the previous result sits under out_stall; reset clears
// the tone state and output valid and loads clock_hz = 16000000
// ----------------------------------------------------------------------------
module tone_prescaler_select_with_duration_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_wr_en,
	input  logic [tpsd_pkg::ClkWidth-1:0]       cfg_wr_data,
	// input item
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          op,
	input  logic [tpsd_pkg::FreqWidth-1:0]      freq_hz,
	input  logic [tpsd_pkg::DurWidth-1:0]       duration_ms,
	// result item
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                active,
	output logic [tpsd_pkg::SelWidth-1:0]       prescale_sel,
	output logic [tpsd_pkg::CmpWidth-1:0]       compare_value,
	output logic                                just_stopped
);

	tpsd_pkg::ctrl_cmd_t  cmd;
	tpsd_pkg::dp_status_t st;
	logic                 in_ready;

	// input stalls whenever the sequencer is busy with an item
	assign in_stall = !in_ready;

	// sequencer: load, divide steps, finish
	tpsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// divider, prescaler pick, tone state and output register
	tpsd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.op            (op),
		.freq_hz       (freq_hz),
		.duration_ms   (duration_ms),
		.cmd           (cmd),
		.st            (st),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.active        (active),
		.prescale_sel  (prescale_sel),
		.compare_value (compare_value),
		.just_stopped  (just_stopped)
	);

endmodule

>>> sim/tone_prescaler_select_with_duration_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tone_prescaler_select_with_duration_core_tb
// self-checking bench: random play/tick/stop traffic against a tone predictor
// ----------------------------------------------------------------------------
module tone_prescaler_select_with_duration_core_tb;

	// prescaler ratios in selection order, /1 first
	localparam longint unsigned PrescDiv [tpsd_pkg::NumPresc] = '{1, 8, 64, 256, 1024};
	localparam longint unsigned CmpMax = 64'hFFFF;
	localparam int NumPhases = 8;
	localparam int RandPerPhase = 190;
	localparam int LongHoldCycles = 300;

	typedef struct packed {
		tpsd_pkg::op_t                  code;
		logic [tpsd_pkg::FreqWidth-1:0] freq;
		logic [tpsd_pkg::DurWidth-1:0]  dur;
	} tone_cmd_t;

	typedef struct packed {
		logic                          on;
		logic [tpsd_pkg::SelWidth-1:0] sel;
		logic [tpsd_pkg::CmpWidth-1:0] cmp;
		logic                          stopped;
	} tone_result_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	// block ports, inputs all known from time zero
	logic                           cfg_wr_en = 1'b0;
	logic [tpsd_pkg::ClkWidth-1:0]  cfg_wr_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [1:0]                     op = tpsd_pkg::OP_NONE;
	logic [tpsd_pkg::FreqWidth-1:0] freq_hz = '0;
	logic [tpsd_pkg::DurWidth-1:0]  duration_ms = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic                           active;
	logic [tpsd_pkg::SelWidth-1:0]  prescale_sel;
	logic [tpsd_pkg::CmpWidth-1:0]  compare_value;
	logic                           just_stopped;

	tone_prescaler_select_with_duration_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.freq_hz       (freq_hz),
		.duration_ms   (duration_ms),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.active        (active),
		.prescale_sel  (prescale_sel),
		.compare_value (compare_value),
		.just_stopped  (just_stopped)
	);

	// pending commands, filled by the sequence below, drained by the driver
	tone_cmd_t    cmd_q [$];
	// predicted results, oldest first
	tone_result_t tone_exp_q [$];
	tone_cmd_t    cur_cmd = '0;

	// predictor copy of the tone state and the clock register
	logic [tpsd_pkg::ClkWidth-1:0] clk_hz_model = tpsd_pkg::ClockReset;
	logic                          tone_on = 1'b0;
	logic                          timed_tone = 1'b0;
	logic [tpsd_pkg::DurWidth-1:0] ms_left = '0;
	logic [tpsd_pkg::SelWidth-1:0] cur_sel = '0;
	logic [tpsd_pkg::CmpWidth-1:0] cur_cmp = '0;

	// pacing controls
	logic idle_on = 1'b1;
	logic hold_arm = 1'b0;
	int   hold_left = 0;
	int   send_gap = 0;
	int   recv_gap = 0;
	int   mismatch_cnt = 0;

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatch_cnt++;
	endtask

	function automatic void silence_tone();
		tone_on = 1'b0;
		timed_tone = 1'b0;
		ms_left = '0;
		cur_sel = '0;
		cur_cmp = '0;
	endfunction

	// advance the predicted tone state by one command, return its result
	function automatic tone_result_t advance_tone(tone_cmd_t cmd);
		tone_result_t    res;
		logic            ended;
		logic            found;
		longint unsigned span;
		longint unsigned quot;
		int              k;
		ended = 1'b0;
		case (cmd.code)
			tpsd_pkg::OP_PLAY: begin
				if (cmd.freq == '0) begin
					// zero frequency behaves as a stop, duration ignored
					ended = tone_on;
					silence_tone();
				end else begin
					// first prescaler whose quotient is nonzero and fits the compare reg
					found = 1'b0;
					cur_sel = tpsd_pkg::FallbackSel;
					cur_cmp = '0;
					for (k = 0; k < tpsd_pkg::NumPresc; k++) begin
						span = 64'd2 * PrescDiv[k] * longint'(cmd.freq);
						quot = longint'(clk_hz_model) / span;
						if (!found && quot != 0 && quot - 1 <= CmpMax) begin
							found = 1'b1;
							cur_sel = tpsd_pkg::SelWidth'(k);
							cur_cmp = tpsd_pkg::CmpWidth'(quot - 1);
						end
					end
					// a new tone replaces a playing one without a stop flag
					tone_on = 1'b1;
					timed_tone = (cmd.dur != '0);
					ms_left = cmd.dur;
				end
			end
			tpsd_pkg::OP_TICK: begin
				// only a timed tone counts down; idle or untimed ignores ticks
				if (tone_on && timed_tone) begin
					if (ms_left != '0)
						ms_left = ms_left - 1'b1;
					if (ms_left == '0) begin
						silence_tone();
						ended = 1'b1;
					end
				end
			end
			tpsd_pkg::OP_STOP: begin
				ended = tone_on;
				silence_tone();
			end
			default: begin
				// unused code: state reported as is
			end
		endcase
		res.on = tone_on;
		res.sel = cur_sel;
		res.cmp = cur_cmp;
		res.stopped = ended;
		return res;
	endfunction

	task automatic push_cmd(tpsd_pkg::op_t code, int f, int d);
		tone_cmd_t c;
		c.code = code;
		c.freq = tpsd_pkg::FreqWidth'(f);
		c.dur = tpsd_pkg::DurWidth'(d);
		cmd_q.push_back(c);
	endtask

	// random traffic: mostly plays with short durations followed by ticks,
	// so tones run out on their own; stops, zero-frequency plays and the
	// unused code mixed in as noise
	function automatic tone_cmd_t random_tone_cmd();
		tone_cmd_t c;
		int        r;
		int        fc;
		int        dc;
		r = $urandom_range(0, 99);
		fc = $urandom_range(0, 3);
		dc = $urandom_range(0, 19);
		c.freq = tpsd_pkg::FreqWidth'($urandom_range(0, 65535));
		c.dur = tpsd_pkg::DurWidth'($urandom_range(0, 65535));
		if (r < 35) begin
			c.code = tpsd_pkg::OP_PLAY;
			case (fc)
				0: c.freq = tpsd_pkg::FreqWidth'($urandom_range(1, 64));
				1: c.freq = tpsd_pkg::FreqWidth'($urandom_range(65, 2000));
				2: c.freq = tpsd_pkg::FreqWidth'($urandom_range(1, 65535));
				default: c.freq = tpsd_pkg::FreqWidth'($urandom_range(60000, 65535));
			endcase
			if (dc < 3)
				c.dur = '0;
			else if (dc < 15)
				c.dur = tpsd_pkg::DurWidth'($urandom_range(1, 6));
			else if (dc < 18)
				c.dur = tpsd_pkg::DurWidth'($urandom_range(7, 40));
		end else if (r < 85) begin
			c.code = tpsd_pkg::OP_TICK;
		end else if (r < 95) begin
			c.code = tpsd_pkg::OP_STOP;
		end else if (r < 98) begin
			c.code = tpsd_pkg::OP_PLAY;
			c.freq = '0;
		end else begin
			c.code = tpsd_pkg::OP_NONE;
		end
		return c;
	endfunction

	// driver: presents pending commands, predicts each one on its transfer
	always @(posedge clk) begin
		tone_cmd_t next_cmd;
		logic      taken;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			taken = in_valid && !in_stall;
			if (taken)
				tone_exp_q.push_back(advance_tone(cur_cmd));
			if (!in_valid || taken) begin
				if (send_gap != 0) begin
					// idle cycles before the next command
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (cmd_q.size() != 0) begin
					next_cmd = cmd_q.pop_front();
					cur_cmd <= next_cmd;
					op <= next_cmd.code;
					freq_hz <= next_cmd.freq;
					duration_ms <= next_cmd.dur;
					in_valid <= 1'b1;
					send_gap <= idle_on ? $urandom_range(0, 10) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, counted on its own once armed
	always @(posedge clk) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (hold_arm)
			hold_left <= LongHoldCycles;
	end

	// monitor: checks each result transfer against the oldest prediction
	always @(posedge clk) begin
		tone_result_t want;
		int           wait_n;
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_gap <= 0;
		end else begin
			wait_n = recv_gap;
			if (out_valid && !out_stall) begin
				if (tone_exp_q.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					want = tone_exp_q.pop_front();
					if (active !== want.on)
						report_mismatch($sformatf("active %b, want %b", active, want.on));
					if (prescale_sel !== want.sel)
						report_mismatch($sformatf("prescale_sel %0d, want %0d",
							prescale_sel, want.sel));
					if (compare_value !== want.cmp)
						report_mismatch($sformatf("compare_value %0d, want %0d",
							compare_value, want.cmp));
					if (just_stopped !== want.stopped)
						report_mismatch($sformatf("just_stopped %b, want %b",
							just_stopped, want.stopped));
				end
				wait_n = idle_on ? $urandom_range(0, 10) : 0;
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				recv_gap <= 0;
			end else if (wait_n != 0) begin
				out_stall <= 1'b1;
				recv_gap <= wait_n - 1;
			end else begin
				out_stall <= 1'b0;
				recv_gap <= 0;
			end
		end
	end

	// sender pauses here until every predicted result has been seen
	task automatic wait_drained();
		@(negedge clk);
		while (!(cmd_q.size() == 0 && tone_exp_q.size() == 0 && !in_valid))
			@(negedge clk);
	endtask

	// register writes only while the block has nothing in flight
	task automatic write_clock(logic [tpsd_pkg::ClkWidth-1:0] hz);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= hz;
		clk_hz_model = hz;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// sequence: directed pass at the reset clock, then random phases over
	// clock settings including zero, one, the top of the range and typical ones
	initial begin
		logic [tpsd_pkg::ClkWidth-1:0] clock_plan [NumPhases];
		logic [tpsd_pkg::ClkWidth-1:0] hz;
		int                            ph;
		int                            n;
		clock_plan = '{27'd1, 27'd100000000, 27'd0, 27'h7FFFFFF, 27'd16000000,
			27'd0, 27'd1000000, 27'd32768};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: idle stop and tick, unused code, field extremes,
		// replacement, zero-frequency stop, expiry, untimed ticks
		push_cmd(tpsd_pkg::OP_STOP, 0, 0);
		push_cmd(tpsd_pkg::OP_TICK, 65535, 65535);
		push_cmd(tpsd_pkg::OP_NONE, 65535, 65535);
		push_cmd(tpsd_pkg::OP_PLAY, 65535, 0);
		push_cmd(tpsd_pkg::OP_TICK, 0, 0);
		push_cmd(tpsd_pkg::OP_NONE, 0, 0);
		push_cmd(tpsd_pkg::OP_PLAY, 1, 65535);
		push_cmd(tpsd_pkg::OP_TICK, 0, 0);
		push_cmd(tpsd_pkg::OP_PLAY, 0, 7);
		push_cmd(tpsd_pkg::OP_PLAY, 0, 0);
		push_cmd(tpsd_pkg::OP_PLAY, 440, 2);
		push_cmd(tpsd_pkg::OP_TICK, 0, 0);
		push_cmd(tpsd_pkg::OP_TICK, 0, 0);
		push_cmd(tpsd_pkg::OP_PLAY, 1000, 1);
		push_cmd(tpsd_pkg::OP_TICK, 0, 0);
		push_cmd(tpsd_pkg::OP_PLAY, 300, 0);
		push_cmd(tpsd_pkg::OP_PLAY, 500, 3);
		push_cmd(tpsd_pkg::OP_STOP, 0, 0);
		push_cmd(tpsd_pkg::OP_PLAY, 16'hAAAA, 16'h5555);
		push_cmd(tpsd_pkg::OP_PLAY, 16'h5555, 16'hAAAA);
		push_cmd(tpsd_pkg::OP_TICK, 0, 0);
		push_cmd(tpsd_pkg::OP_STOP, 0, 0);
		push_cmd(tpsd_pkg::OP_PLAY, 30, 1);
		push_cmd(tpsd_pkg::OP_TICK, 0, 0);

		for (ph = 0; ph < NumPhases; ph++) begin
			wait_drained();
			hz = (ph == 5) ? tpsd_pkg::ClkWidth'($urandom_range(1, 100000000))
				: clock_plan[ph];
			write_clock(hz);
			// one phase runs with no idling on either side
			idle_on = (ph != 4);
			for (n = 0; n < RandPerPhase; n++)
				cmd_q.push_back(random_tone_cmd());
			if (ph == 2) begin
				// receiver stalls long while commands keep coming
				hold_arm = 1'b1;
				@(negedge clk);
				hold_arm = 1'b0;
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// run limit
	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> filelist.f
rtl/tpsd_pkg.sv
rtl/tpsd_ctrl.sv
rtl/tpsd_dp.sv
rtl/tone_prescaler_select_with_duration_core.sv
sim/tone_prescaler_select_with_duration_core_tb.sv
